// ===== sv/b2d_pkg.sv =====
// shared constants and types for the binary to decimal digit unit
`default_nettype none

package b2d_pkg;

    localparam int VALUE_BITS = 64;
    localparam int DIGIT_CAP  = 20;
    localparam int DIGIT_W    = 4;
    localparam int LIMIT_W    = 5;
    localparam int IDX_W      = $clog2(DIGIT_CAP);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    localparam logic [LIMIT_W-1:0] MAX_DIGITS_RESET = LIMIT_W'(20);

    typedef logic [DIGIT_CAP-1:0][DIGIT_W-1:0] digits_t;

    typedef struct packed {
        logic busy;
        logic done;
    } conv_status_t;

endpackage

`default_nettype wire

// ===== sv/binary_to_decimal_digits_unit.sv =====
// top level: converts a binary value into decimal digits, most significant first
// flow: an accepted beat starts the converter; once it reports done, the digits are emitted from ST_EMIT
// the input stalls outside ST_IDLE, so one value is converted at a time by the one-bit-per-cycle
//   shift-and-add-three converter, then sent out one digit per cycle while out_stall is low
// the next input beat is taken while the last digit still waits at the output
// reset: asynchronous active low, max_digits returns to 20, no beat pending
`default_nettype none

module binary_to_decimal_digits_unit
    import b2d_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [63:0]        value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DIGIT_W-1:0]      digit,
    output logic                    is_last,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LIMIT_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [LIMIT_W-1:0] max_digits_reg;
    logic [LIMIT_W-1:0] limit;
    logic [LIMIT_W-1:0] count;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               is_last_reg, is_last_next;
    logic               in_accept;
    logic               out_free;
    conv_status_t       conv_status;
    digits_t            conv_bcd;
    logic [LIMIT_W-1:0] conv_len;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    b2d_dabble u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_accept),
        .value  (value[VALUE_BITS-1:0]),
        .status (conv_status),
        .bcd    (conv_bcd),
        .len    (conv_len)
    );

    // zero acts as one, anything above the cap acts as the cap
    always_comb
    begin
        if (max_digits_reg == '0)
        begin
            limit = LIMIT_W'(1);
        end
        else if (max_digits_reg > LIMIT_W'(DIGIT_CAP))
        begin
            limit = LIMIT_W'(DIGIT_CAP);
        end
        else
        begin
            limit = max_digits_reg;
        end
        count = (conv_len < limit) ? conv_len : limit;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        digit_next     = digit_reg;
        is_last_next   = is_last_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_status.done)
                begin
                    idx_next   = IDX_W'(count - LIMIT_W'(1));
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    digit_next     = conv_bcd[idx_reg];
                    is_last_next   = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            max_digits_reg <= MAX_DIGITS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_digits_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        digit_reg   <= digit_next;
        is_last_reg <= is_last_next;
    end

    assign out_valid = out_valid_reg;
    assign digit     = digit_reg;
    assign is_last   = is_last_reg;

    // checks

    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_status.done |-> (state_reg == ST_CONV))
        else $error("converter finished outside conversion");

    a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> conv_status.busy && (state_reg == ST_CONV))
        else $error("accepted beat did not start a conversion");

    a_idx_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (LIMIT_W'(idx_reg) < limit))
        else $error("digit index beyond limit");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (digit_reg <= DIGIT_W'(9)))
        else $error("digit out of decimal range");

endmodule

`default_nettype wire

// ===== sv/b2d_dabble.sv =====
// bit-serial shift-and-add-three converter from binary to packed decimal digits
`default_nettype none

module b2d_dabble
    import b2d_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] value,
    output conv_status_t               status,
    output digits_t                    bcd,
    output logic [LIMIT_W-1:0]         len
);

    logic [VALUE_BITS-1:0] bits_reg, bits_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    digits_t               bcd_reg, bcd_next;
    digits_t               adj;
    logic [LIMIT_W-1:0]    len_reg, len_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    // add three to every digit of five or more, then shift in the next bit
    always_comb
    begin
        for (int i = 0; i < DIGIT_CAP; i++)
        begin
            adj[i] = (bcd_reg[i] >= DIGIT_W'(5)) ? bcd_reg[i] + DIGIT_W'(3) : bcd_reg[i];
        end
    end

    always_comb
    begin
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        bcd_next  = bcd_reg;
        len_next  = len_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bits_next = value;
            cnt_next  = CNT_W'(VALUE_BITS);
            bcd_next  = '0;
            len_next  = LIMIT_W'(1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next  = digits_t'({adj, bits_reg[VALUE_BITS-1]});
            bits_next = {bits_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            // significant digits grow by at most one per shifted bit
            if (len_reg < LIMIT_W'(DIGIT_CAP))
            begin
                if (bcd_next[len_reg[IDX_W-1:0]] != '0)
                begin
                    len_next = len_reg + LIMIT_W'(1);
                end
            end
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        bcd_reg  <= bcd_next;
        len_reg  <= len_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;
    assign len         = len_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for binary_to_decimal_digits_unit: queued values in, digit beats checked in order
`timescale 1ns / 100ps

module tb
    import b2d_pkg::*;
();

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               is_last;
    } digit_beat_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [63:0]        value     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [DIGIT_W-1:0] digit;
    logic               is_last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data  = '0;

    logic [63:0]        values_pending[$];
    digit_beat_t        digits_due[$];
    logic [LIMIT_W-1:0] digit_limit = MAX_DIGITS_RESET;
    logic               quiet       = 1'b0;
    int                 hold_req    = 0;
    int                 n_err       = 0;
    int                 n_items     = 0;
    int                 n_digits    = 0;
    int                 n_cfg       = 0;

    binary_to_decimal_digits_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .digit     (digit),
        .is_last   (is_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // decimal digits of v, most significant first, lowest lim kept (zero taken as one, above the cap as the cap)
    function automatic void queue_digits(input logic [63:0] v, input logic [LIMIT_W-1:0] lim);
        logic [DIGIT_W-1:0] rev[DIGIT_CAP];
        logic [63:0]        q;
        int                 keep;
        int                 len;
        digit_beat_t        beat;
        q = v;
        if (VALUE_BITS < 64)
            q = v & ((64'd1 << VALUE_BITS) - 64'd1);
        keep = (lim == 0) ? 1 : (lim > DIGIT_CAP) ? DIGIT_CAP : int'(lim);
        len = 0;
        do
        begin
            rev[len] = DIGIT_W'(q % 64'd10);
            q = q / 64'd10;
            len++;
        end
        while (len < keep && q != 0);
        for (int k = len - 1; k >= 0; k--)
        begin
            beat.digit   = rev[k];
            beat.is_last = (k == 0);
            digits_due.push_back(beat);
        end
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        logic [63:0] p;
        v = {$urandom, $urandom};
        p = 64'd1;
        case ($urandom_range(0, 5))
            0, 1: rand_value = v;
            2: rand_value = v >> $urandom_range(1, 63);
            3: rand_value = 64'($urandom_range(0, 999));
            default:
            begin
                repeat ($urandom_range(1, 19)) p = p * 64'd10;
                rand_value = p - 64'd1 + 64'($urandom_range(0, 2));
            end
        endcase
    endfunction

    // input driver
    int in_gap = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                queue_digits(value, digit_limit);
                n_items++;
            end
            if (!(in_valid && in_stall))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (values_pending.size() > 0)
                begin
                    value    <= values_pending.pop_front();
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 3) == 0)
                        in_gap = $urandom_range(1, 14);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // digit monitor and output stall
    int out_hold  = 0;
    int hold_seen = 0;
    always @(posedge clk)
    begin : digit_monitor
        digit_beat_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid === 1'b1 && !out_stall)
            begin
                n_digits++;
                if (digits_due.size() == 0)
                begin
                    $error("digit beat %0d (is_last %0b) with nothing expected", digit, is_last);
                    n_err++;
                end
                else
                begin
                    want = digits_due.pop_front();
                    if (digit !== want.digit)
                    begin
                        $error("digit: expected %0d, got %0d", want.digit, digit);
                        n_err++;
                    end
                    if (is_last !== want.is_last)
                    begin
                        $error("is_last: expected %0b, got %0b", want.is_last, is_last);
                        n_err++;
                    end
                end
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                out_hold  = 300;
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_hold = $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        @(posedge clk);
        cfg_data  <= lim;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        digit_limit = lim;
        n_cfg++;
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (values_pending.size() != 0 || in_valid || digits_due.size() != 0);
    endtask

    task automatic push_random(input int n);
        repeat (n) values_pending.push_back(rand_value());
    endtask

    initial
    begin : stimulus
        logic [LIMIT_W-1:0] lim;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset limit of twenty digits
        values_pending = {64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, '1,
                          64'd10000000000000000000, 64'd9999999999999999999,
                          64'd12345678901234567890, 64'h8000_0000_0000_0000,
                          64'h0000_0000_8000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
                          64'h5555_5555_5555_5555};
        wait_drained();

        // one digit kept, truncation may leave a leading zero
        write_limit(LIMIT_W'(1));
        values_pending = {64'd0, 64'd7, '1, 64'd10};
        wait_drained();

        // zero limit acts as one
        write_limit(LIMIT_W'(0));
        values_pending = {64'd5, '1};
        wait_drained();

        // limit above twenty acts as twenty
        write_limit(LIMIT_W'(31));
        values_pending = {'1, 64'd0};
        wait_drained();

        write_limit(LIMIT_W'(5));
        values_pending = {64'd100000, 64'd123456};
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            lim = (p == 0) ? LIMIT_W'(19) : (p == 1) ? LIMIT_W'(21)
                                                     : LIMIT_W'($urandom_range(0, 31));
            write_limit(lim);
            // long receiver hold-off while the sender keeps offering
            if (p == 1)
            begin
                @(negedge clk);
                hold_req = hold_req + 1;
            end
            push_random(16);
            wait_drained();
        end

        @(negedge clk);
        quiet = 1'b1;
        write_limit(MAX_DIGITS_RESET);
        push_random(30);
        wait_drained();

        repeat (100) @(posedge clk);
        $display("run covered %0d values and %0d digit beats under %0d digit-limit settings",
                 n_items, n_digits, n_cfg + 1);
        $display("limits included zero, one, twenty and the 5-bit maximum, with stalls on both sides");
        if (n_err == 0)
            $display("** binary_to_decimal_digits_unit: PASSED **");
        else
            $display("** binary_to_decimal_digits_unit: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("timeout waiting for digit beats");
        $display("** binary_to_decimal_digits_unit: FAILED **");
        $finish;
    end

endmodule
